/* sv/swm_pkg.sv */
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants of the sliding window maximum filter.
// ----------------------------------------------------------------------------
package swm_pkg;

    // Width of the window_size register
    localparam int CFG_W = 7;

    // APB data width
    localparam int APB_DW = 32;

    // Register index taken from the word address bit
    localparam logic REG_WINDOW_SIZE = 1'b0;

    // Control part of the scan token that walks down the cell row
    typedef struct packed {
        logic vld;   // token present
        logic last;  // token belongs to the last sample of a stream
    } t_tok_ctl;

endpackage

/* sv/swm_cell.sv */
// ----------------------------------------------------------------------------
// swm_cell
// One cell of the window row: holds one past sample, shifts it on to the
// next cell when a new sample enters, and folds its sample into a passing
// scan token.
// ----------------------------------------------------------------------------
module swm_cell
    import swm_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int KW           = 7
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // sample shift path
    input  logic                    i_shift,
    input  logic [SAMPLE_WIDTH-1:0] i_data,
    output logic [SAMPLE_WIDTH-1:0] o_data,
    // scan token from the previous cell
    input  t_tok_ctl                i_ctl,
    input  logic [KW-1:0]           i_remain,
    input  logic [SAMPLE_WIDTH-1:0] i_max,
    // scan token to the next cell
    output t_tok_ctl                o_ctl,
    output logic [KW-1:0]           o_remain,
    output logic [SAMPLE_WIDTH-1:0] o_max,
    output logic                    o_done
);

    logic [SAMPLE_WIDTH-1:0] r_data;
    logic                    r_vld;
    logic                    r_last;
    logic [KW-1:0]           r_remain;
    logic [SAMPLE_WIDTH-1:0] r_max;
    logic                    n_active;
    logic [SAMPLE_WIDTH-1:0] n_max;

    // token does work here only while samples remain to be covered
    assign n_active = i_ctl.vld && (i_remain != '0);
    assign n_max    = ($signed(r_data) > $signed(i_max)) ? r_data : i_max;

    // stored sample
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_data;
        end
    end

    // token payload
    always_ff @(posedge i_clk) begin
        r_last   <= i_ctl.last;
        r_remain <= i_remain - KW'(1);
        r_max    <= n_max;
    end

    // token presence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_active;
        end
    end

    assign o_data     = r_data;
    assign o_ctl.vld  = r_vld;
    assign o_ctl.last = r_last;
    assign o_remain   = r_remain;
    assign o_max      = r_max;
    // this cell covered the oldest sample of the window
    assign o_done     = r_vld && (r_remain == '0);

endmodule

/* sv/swm_chain.sv */
// ----------------------------------------------------------------------------
// swm_chain
// Row of window cells, newest sample in cell 0, and the collection of the
// finished scan token from whichever cell completes it.
// ----------------------------------------------------------------------------
module swm_chain
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 16,
    parameter int KW           = 7
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_shift,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    input  t_tok_ctl                i_ctl,
    input  logic [KW-1:0]           i_remain,
    output logic                    o_done,
    output logic                    o_last,
    output logic [SAMPLE_WIDTH-1:0] o_max
);

    logic [SAMPLE_WIDTH-1:0] w_data   [WINDOW_MAX+1];
    t_tok_ctl                w_ctl    [WINDOW_MAX+1];
    logic [KW-1:0]           w_remain [WINDOW_MAX+1];
    logic [SAMPLE_WIDTH-1:0] w_max    [WINDOW_MAX+1];
    logic [WINDOW_MAX-1:0]   w_done;

    // head of the row: new sample and a fresh token starting at the minimum
    assign w_data[0]   = i_sample;
    assign w_ctl[0]    = i_ctl;
    assign w_remain[0] = i_remain;
    assign w_max[0]    = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        swm_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .KW           (KW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (i_shift),
            .i_data   (w_data[g]),
            .o_data   (w_data[g+1]),
            .i_ctl    (w_ctl[g]),
            .i_remain (w_remain[g]),
            .i_max    (w_max[g]),
            .o_ctl    (w_ctl[g+1]),
            .o_remain (w_remain[g+1]),
            .o_max    (w_max[g+1]),
            .o_done   (w_done[g])
        );
    end

    // at most one cell finishes in a cycle: OR-select its token
    always_comb begin
        o_done = 1'b0;
        o_last = 1'b0;
        o_max  = '0;
        for (int i = 0; i < WINDOW_MAX; i++) begin
            o_done = o_done | w_done[i];
            o_last = o_last | (w_done[i] & w_ctl[i+1].last);
            o_max  = o_max | (w_done[i] ? w_max[i+1] : '0);
        end
    end

endmodule

/* sv/sliding_window_maximum.sv */
// ----------------------------------------------------------------------------
// sliding_window_maximum
// Streaming filter giving the maximum of the newest window_size samples.
// ----------------------------------------------------------------------------
// Samples enter on the s_axis channel (tdata = sample, tlast = end of stream).
// Each sample that completes a full window gives one transfer on m_axis
// (tdata = window maximum, tlast = caused by the stream's last sample); the
// first window_size-1 samples of a stream give none, window_size taken as 1..WINDOW_MAX.
// window_size is set over APB at byte address 0; the user must set it only while
// the block is idle, and the block itself does not enforce this. Samples live in
// a row of WINDOW_MAX cells that shift on every accepted sample. A sample that
// gives a result launches a scan token that walks the row one cell per cycle;
// s_axis_tready stays low until that token finishes. A sample that gives no
// result does not hold off the next sample.
// The output register plus a one-entry hold register let a new sample enter
// while a result still waits; if both are full, s_axis_tready stays low
// until m_axis takes a result.
// Reset clears the stream fill count, the tokens and the output flags and sets
// window_size to 1; stored samples are not cleared.
// ----------------------------------------------------------------------------
module sliding_window_maximum
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // APB configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [2:0]                            paddr,
    input  logic [APB_DW-1:0]                     pwdata,
    output logic [APB_DW-1:0]                     prdata,
    output logic                                  pready,
    // sample input
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,  // [SW-1:0] sample
    input  logic                                  s_axis_tlast,  // last_sample
    // result output
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     m_axis_tdata,  // [SW-1:0] window_max
    output logic                                  m_axis_tlast   // last_result
);

    localparam int KW = $clog2(WINDOW_MAX + 1);
    localparam int DW = ((SAMPLE_WIDTH + 7) / 8) * 8;

    logic [CFG_W-1:0]        r_wsize;
    logic [KW-1:0]           r_fill;
    logic                    r_busy;
    t_tok_ctl                r_launch;
    logic [KW-1:0]           r_launch_remain;
    logic                    r_out_vld;
    logic                    r_out_last;
    logic [SAMPLE_WIDTH-1:0] r_out_data;
    logic                    r_hold_vld;
    logic                    r_hold_last;
    logic [SAMPLE_WIDTH-1:0] r_hold_data;

    logic [KW-1:0]           w_k;
    logic [KW-1:0]           n_fill;
    logic                    w_produce;
    logic                    w_in_xfer;
    logic                    w_out_free;
    logic                    w_done;
    logic                    w_done_last;
    logic [SAMPLE_WIDTH-1:0] w_done_max;
    logic                    w_wr;

    // APB register access
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && (paddr[2] == REG_WINDOW_SIZE);
    assign prdata = (paddr[2] == REG_WINDOW_SIZE) ? APB_DW'(r_wsize) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsize <= CFG_W'(1);
        end else if (w_wr) begin
            r_wsize <= pwdata[CFG_W-1:0];
        end
    end

    // effective window length, clamped to 1..WINDOW_MAX
    always_comb begin
        if (r_wsize == '0) begin
            w_k = KW'(1);
        end else if (32'(r_wsize) > 32'(WINDOW_MAX)) begin
            w_k = KW'(WINDOW_MAX);
        end else begin
            w_k = KW'(r_wsize);
        end
    end

    // fill count of the current stream, saturating at WINDOW_MAX
    assign n_fill    = (32'(r_fill) < 32'(WINDOW_MAX)) ? r_fill + KW'(1) : r_fill;
    assign w_produce = (n_fill >= w_k);

    assign s_axis_tready = !r_busy && !r_hold_vld;
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;

    // stream control and token launch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_busy       <= 1'b0;
            r_launch.vld <= 1'b0;
        end else begin
            r_launch.vld <= w_in_xfer && w_produce;
            if (w_in_xfer) begin
                r_fill          <= s_axis_tlast ? '0 : n_fill;
                r_busy          <= w_produce;
                r_launch.last   <= s_axis_tlast;
                r_launch_remain <= w_k;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    // cell row
    swm_chain #(
        .WINDOW_MAX   (WINDOW_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .KW           (KW)
    ) u_chain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (w_in_xfer),
        .i_sample (s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .i_ctl    (r_launch),
        .i_remain (r_launch_remain),
        .o_done   (w_done),
        .o_last   (w_done_last),
        .o_max    (w_done_max)
    );

    // output register with a one-entry hold stage behind it
    assign w_out_free = !r_out_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_hold_vld <= 1'b0;
        end else begin
            if (w_out_free) begin
                if (r_hold_vld) begin
                    r_out_vld  <= 1'b1;
                    r_hold_vld <= 1'b0;
                end else begin
                    r_out_vld <= w_done;
                end
            end else if (w_done) begin
                r_hold_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_hold_vld) begin
                r_out_data <= r_hold_data;
                r_out_last <= r_hold_last;
            end else if (w_done) begin
                r_out_data <= w_done_max;
                r_out_last <= w_done_last;
            end
        end else if (w_done) begin
            r_hold_data <= w_done_max;
            r_hold_last <= w_done_last;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = DW'(r_out_data);
    assign m_axis_tlast  = r_out_last;

endmodule

/* tb/tb_sliding_window_maximum.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_maximum
// Self-checking testbench for the sliding window maximum filter.
// ----------------------------------------------------------------------------
// A clocked driver sends samples from a queue that the stimulus process fills.
// A clocked monitor runs every accepted sample through a local window model and
// compares each m_axis transfer with the oldest predicted maximum. The run
// starts with a directed part and continues with random phases. Each phase
// uses its own window size and idle pattern, and one phase holds the output
// off for a long stretch so the block backs up. window_size is only written
// over APB while the block is idle.
// ----------------------------------------------------------------------------
module tb_sliding_window_maximum;
    import swm_pkg::*;

    localparam int WIN_DEPTH   = 64;
    localparam int SW          = 16;
    localparam int DRAIN_WAIT  = WIN_DEPTH + 16;  // covers one full scan
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int N_PHASE     = 12;

    localparam logic [2:0] ADDR_WIN_SIZE = {REG_WINDOW_SIZE, 2'b00};
    localparam logic [2:0] ADDR_SPARE    = {~REG_WINDOW_SIZE, 2'b00};

    typedef enum int {PAT_NOISE, PAT_RISE, PAT_FALL, PAT_FLOOR} t_pattern;

    typedef struct {
        logic signed [SW-1:0] value;
        logic                 last;
    } t_sample;

    typedef struct {
        logic signed [SW-1:0] wmax;
        logic                 last;
    } t_wmax;

    // clock, reset and block inputs, all known from time zero
    logic              i_clk    = 1'b0;
    logic              i_rst_n  = 1'b0;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [2:0]        paddr    = '0;
    logic [APB_DW-1:0] pwdata   = '0;
    logic              s_tvalid = 1'b0;
    logic [SW-1:0]     s_tdata  = '0;
    logic              s_tlast  = 1'b0;
    logic              m_tready = 1'b0;

    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              s_axis_tready;
    logic              m_axis_tvalid;
    logic [SW-1:0]     m_axis_tdata;
    logic              m_axis_tlast;

    // stimulus and scoreboard
    t_sample sample_q[$];
    t_wmax   max_expect_q[$];
    int      push_cnt = 0;
    int      accept_cnt = 0;
    int      err_cnt = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    bit      hold_req = 1'b0;
    int      hold_left = 0;
    int      stall_cycles = 0;

    // local window model
    logic signed [SW-1:0] win_hist [WIN_DEPTH];
    int                   hist_fill = 0;
    logic [5:0]           hist_wptr = '0;
    logic [CFG_W-1:0]     win_cfg = 7'd1;

    // random phase plan: window size, item count, idle pattern
    int phase_cfg   [N_PHASE] = '{4, 1, 2, 7, 0, 64, 12, 3, 127, 5, 33, 9};
    int phase_items [N_PHASE] = '{80, 80, 70, 70, 70, 120, 70, 70, 110, 60, 80, 60};
    int send_pct_tab[4] = '{0, 55, 0, 8};
    int recv_pct_tab[4] = '{0, 0, 55, 8};

    always #6 i_clk = ~i_clk;

    sliding_window_maximum #(
        .WINDOW_MAX  (WIN_DEPTH),
        .SAMPLE_WIDTH(SW)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_axis_tvalid(s_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_tdata),      // [15:0] sample
        .s_axis_tlast (s_tlast),      // last_sample
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_tready),
        .m_axis_tdata (m_axis_tdata), // [15:0] window_max
        .m_axis_tlast (m_axis_tlast)  // last_result
    );

    // Model one accepted sample; queue the maximum if the window is full
    function automatic void predict_window_max(input t_sample smp);
        int                   span;
        int                   i;
        logic [5:0]           idx;
        logic signed [SW-1:0] best;
        t_wmax                res;
        span = (win_cfg == 0) ? 1 : ((win_cfg > WIN_DEPTH) ? WIN_DEPTH : int'(win_cfg));
        win_hist[hist_wptr] = smp.value;
        hist_wptr = hist_wptr + 6'd1;
        if (hist_fill < WIN_DEPTH)
            hist_fill++;
        if (hist_fill >= span) begin
            best = smp.value;
            // newest sample sits at wptr-1, older ones further back
            for (i = 1; i < span; i++) begin
                idx = hist_wptr - 6'd1 - 6'(i);
                if (win_hist[idx] > best)
                    best = win_hist[idx];
            end
            res.wmax = best;
            res.last = smp.last;
            max_expect_q.push_back(res);
        end
        if (smp.last)
            hist_fill = 0;
    endfunction

    function automatic void push_sample(input logic [SW-1:0] value, input logic last);
        t_sample smp;
        smp.value = value;
        smp.last  = last;
        sample_q.push_back(smp);
        push_cnt++;
    endfunction

    // APB write: setup cycle, then access cycle; the register takes it at the
    // edge that closes the access cycle
    task automatic apb_write(input logic [2:0] addr, input logic [APB_DW-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2] == REG_WINDOW_SIZE)
            win_cfg = data[CFG_W-1:0];
    endtask

    // Wait until every sample is taken and every maximum has come out, then
    // give a trailing no-result sample time to finish
    task automatic wait_drain();
        while (accept_cnt != push_cnt || max_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Random streams for one phase: mostly streams at least as long as the window,
    // some no longer than the window
    task automatic fill_phase(input int cfg, input int n_items);
        int            span;
        int            left;
        int            len;
        int            j;
        int            step;
        t_pattern      pat;
        logic [SW-1:0] base;
        logic [SW-1:0] v;
        logic          close;
        span = (cfg == 0) ? 1 : ((cfg > WIN_DEPTH) ? WIN_DEPTH : cfg);
        left = n_items;
        while (left > 0) begin
            if ($urandom_range(0, 4) == 0)
                len = $urandom_range(1, span);
            else
                len = span + $urandom_range(0, 2 * span + 8);
            if (len > left)
                len = left;
            pat  = t_pattern'($urandom_range(0, 3));
            base = SW'($urandom());
            step = $urandom_range(1, 300);
            for (j = 0; j < len; j++) begin
                case (pat)
                    PAT_NOISE: begin
                        if ($urandom_range(0, 7) == 0)
                            v = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                        else
                            v = SW'($urandom());
                    end
                    PAT_RISE:  v = base + SW'(j * step);
                    PAT_FALL:  v = base - SW'(j * step);
                    default: begin
                        // floor at the minimum with rare spikes
                        v = ($urandom_range(0, 9) == 0) ? SW'($urandom()) : 16'h8000;
                    end
                endcase
                // the phase's tail stream is sometimes left open
                close = (j == len - 1) && (len < left || $urandom_range(0, 3) != 0);
                push_sample(v, close);
            end
            left -= len;
        end
    endtask

    // Sample driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_axis_tready) begin
            if (sample_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= sample_q[0].value;
                s_tlast  <= sample_q[0].last;
                sample_q.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result ready: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Monitor: predict on input transfers, check on output transfers
    always @(posedge i_clk) begin
        t_sample smp;
        t_wmax   exp_r;
        if (i_rst_n) begin
            if (s_tvalid && s_axis_tready) begin
                smp.value = s_tdata;
                smp.last  = s_tlast;
                predict_window_max(smp);
                accept_cnt++;
            end
            if (m_axis_tvalid && m_tready) begin
                if (max_expect_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("ERROR: unexpected result max=%0d last=%0b",
                                 $signed(m_axis_tdata), m_axis_tlast);
                end else begin
                    exp_r = max_expect_q.pop_front();
                    if (m_axis_tdata !== exp_r.wmax || m_axis_tlast !== exp_r.last) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("ERROR: max exp %0d got %0d, last exp %0b got %0b",
                                     exp_r.wmax, $signed(m_axis_tdata),
                                     exp_r.last, m_axis_tlast);
                    end
                end
            end
        end
    end

    // Watchdog: counts cycles without a transfer while work is pending
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready) ||
            (accept_cnt == push_cnt && max_expect_q.size() == 0)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Stimulus
    initial begin
        int p;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // window of one after reset: each sample is its own maximum
        push_sample(16'h7FFF, 1'b0);
        push_sample(16'h8000, 1'b0);
        push_sample(16'h0000, 1'b0);
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'h0001, 1'b1);
        wait_drain();

        // size zero behaves as one
        apb_write(ADDR_WIN_SIZE, 32'd0);
        push_sample(16'h5555, 1'b0);
        push_sample(16'hAAAA, 1'b1);
        wait_drain();

        // stream closed before its window fills, then a negative maximum
        apb_write(ADDR_WIN_SIZE, 32'd3);
        push_sample(16'd100, 1'b0);
        push_sample(-16'sd100, 1'b1);
        push_sample(16'h8000, 1'b0);
        push_sample(-16'sd5, 1'b0);
        push_sample(16'h8000, 1'b0);
        push_sample(16'd7, 1'b1);
        wait_drain();

        // size grows mid-stream; samples already taken count toward it
        apb_write(ADDR_WIN_SIZE, 32'd2);
        push_sample(16'd10, 1'b0);
        push_sample(16'd20, 1'b0);
        wait_drain();
        apb_write(ADDR_WIN_SIZE, 32'd4);
        apb_write(ADDR_SPARE, 32'd1);   // no register here, write ignored
        push_sample(16'd5, 1'b0);
        push_sample(16'd1, 1'b1);
        wait_drain();

        // random phases; upper pwdata bits are noise the register drops
        for (p = 0; p < N_PHASE; p++) begin
            apb_write(ADDR_WIN_SIZE, ($urandom() & ~32'h7F) | phase_cfg[p]);
            send_idle_pct  = send_pct_tab[p % 4];
            recv_stall_pct = recv_pct_tab[p % 4];
            fill_phase(phase_cfg[p], phase_items[p]);
            if (p == 0)
                hold_req = 1'b1;
            wait_drain();
        end

        if (err_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
